// File: hdl/atp_pkg.sv
// Shared types, widths and the arctangent table for the tilt angle pipeline.
package atp_pkg;

  localparam int RootWidth   = 32;
  localparam int RemWidth    = 2 * RootWidth;
  localparam int GuardBits   = 26;
  localparam int CordicWidth = 62;
  localparam int AngleWidth  = 29;
  localparam int AngleFrac   = 13;
  localparam int OutWidth    = 15;
  localparam int AngleLimit  = 11520;
  localparam int TableLen    = 24;

  localparam logic signed [AngleWidth-1:0] ATAN_TBL [TableLen] = '{
    29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121, 29'sd3750058,
    29'sd1876857, 29'sd938658, 29'sd469357, 29'sd234682, 29'sd117342,
    29'sd58671, 29'sd29335, 29'sd14668, 29'sd7334, 29'sd3667, 29'sd1833,
    29'sd917, 29'sd458, 29'sd229, 29'sd115, 29'sd57, 29'sd29, 29'sd14, 29'sd7
  };

  typedef struct packed {
    logic zero;
    logic dz_roll;
    logic dz_pitch;
    logic neg_roll;
    logic neg_pitch;
  } tag_t;

  typedef struct packed {
    logic [RemWidth-1:0]           rem;
    logic [RootWidth-1:0]          root;
    logic signed [CordicWidth-1:0] y0;
  } sq_lane_t;

  typedef struct packed {
    logic signed [CordicWidth-1:0] x;
    logic signed [CordicWidth-1:0] y;
    logic signed [AngleWidth-1:0]  z;
  } cr_lane_t;

endpackage

// File: hdl/accel_tilt_angles.sv
// Top level: roll and pitch from a three-axis accelerometer sample.
//
//  channel | dir | beat content
//  s_*     | in  | tdata: accel_x, accel_y, accel_z (SAMPLE_WIDTH bits each, low first)
//  m_*     | out | tdata: roll_angle[14:0], pitch_angle[29:15]; tuser: zero_vector
//
// One beat is taken per cycle while the output skid register is empty; a beat
// passes the squaring stages, the 32 root cells, the CORDIC cells and the output register.
// Synchronous reset clears all valid flags; no clearing pass is needed.
// The whole chain holds while the output skid register is full; s_tready
// then stays low until the master side takes a beat.
module accel_tilt_angles
  import atp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // accel_x, accel_y, accel_z, zero fill
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // roll_angle, pitch_angle, zero fill
  output logic [31:0]                        m_tdata,
  // zero_vector
  output logic [0:0]                         m_tuser
);

  localparam int SW       = SAMPLE_WIDTH;
  localparam int FracBits = 32 - SW;
  localparam int YShift   = FracBits + GuardBits;

  logic en;
  logic skid_full;

  assign en       = !skid_full;
  assign s_tready = en;

  logic signed [SW-1:0] ax, ay, az;
  assign ax = s_tdata[SW-1:0];
  assign ay = s_tdata[2*SW-1:SW];
  assign az = s_tdata[3*SW-1:2*SW];

  logic [SW-1:0] mx, my, mz;
  assign mx = ax[SW-1] ? SW'(-ax) : SW'(ax);
  assign my = ay[SW-1] ? SW'(-ay) : SW'(ay);
  assign mz = az[SW-1] ? SW'(-az) : SW'(az);

  logic                          v1;
  tag_t                          tag1;
  tag_t                          tag1_next;
  logic [2*SW-1:0]               xx, yy, zz;
  logic signed [CordicWidth-1:0] yr1, yp1;

  always_comb begin
    tag1_next.zero      = (ax == '0) && (ay == '0) && (az == '0);
    tag1_next.dz_roll   = 1'b0;
    tag1_next.dz_pitch  = 1'b0;
    tag1_next.neg_roll  = ay[SW-1];
    tag1_next.neg_pitch = ax[SW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx   <= mx * mx;
      yy   <= my * my;
      zz   <= mz * mz;
      yr1  <= CordicWidth'(ay) <<< YShift;
      yp1  <= CordicWidth'(ax) <<< YShift;
      tag1 <= tag1_next;
    end
  end

  logic [2*SW:0] den_roll, den_pitch;
  assign den_roll  = {1'b0, xx} + {1'b0, zz};
  assign den_pitch = {1'b0, yy} + {1'b0, zz};

  logic           sq_valid [RootWidth+1];
  tag_t           sq_tag   [RootWidth+1];
  sq_lane_t [1:0] sq_lane  [RootWidth+1];

  tag_t           sq_tag0_next;
  sq_lane_t [1:0] sq_lane0_next;

  always_comb begin
    sq_tag0_next          = tag1;
    sq_tag0_next.dz_roll  = (den_roll == '0);
    sq_tag0_next.dz_pitch = (den_pitch == '0);
    sq_lane0_next[0].rem  = {den_roll[2*SW-1:0], {(2*FracBits){1'b0}}};
    sq_lane0_next[0].root = '0;
    sq_lane0_next[0].y0   = yr1;
    sq_lane0_next[1].rem  = {den_pitch[2*SW-1:0], {(2*FracBits){1'b0}}};
    sq_lane0_next[1].root = '0;
    sq_lane0_next[1].y0   = yp1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (en) begin
      sq_valid[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_tag[0]  <= sq_tag0_next;
      sq_lane[0] <= sq_lane0_next;
    end
  end

  for (genvar k = 0; k < RootWidth; k++) begin : g_sqrt
    atp_sqrt_cell #(.BIT(RootWidth - 1 - k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_valid[k]),
      .in_tag    (sq_tag[k]),
      .in_lane   (sq_lane[k]),
      .out_valid (sq_valid[k+1]),
      .out_tag   (sq_tag[k+1]),
      .out_lane  (sq_lane[k+1])
    );
  end

  logic           cr_valid [CORDIC_STEPS+1];
  tag_t           cr_tag   [CORDIC_STEPS+1];
  cr_lane_t [1:0] cr_lane  [CORDIC_STEPS+1];

  assign cr_valid[0] = sq_valid[RootWidth];
  assign cr_tag[0]   = sq_tag[RootWidth];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      cr_lane[0][l].x = CordicWidth'({sq_lane[RootWidth][l].root, {GuardBits{1'b0}}});
      cr_lane[0][l].y = sq_lane[RootWidth][l].y0;
      cr_lane[0][l].z = '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    atp_cordic_cell #(.STEP(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cr_valid[i]),
      .in_tag    (cr_tag[i]),
      .in_lane   (cr_lane[i]),
      .out_valid (cr_valid[i+1]),
      .out_tag   (cr_tag[i+1]),
      .out_lane  (cr_lane[i+1])
    );
  end

  logic                       res_valid;
  tag_t                       rt;
  logic signed [OutWidth-1:0] ang [2];
  logic [31:0]                res_data;

  assign res_valid = cr_valid[CORDIC_STEPS];
  assign rt        = cr_tag[CORDIC_STEPS];

  always_comb begin
    logic signed [AngleWidth-1:0] r;
    logic dz, neg;
    for (int l = 0; l < 2; l++) begin
      dz  = (l == 0) ? rt.dz_roll : rt.dz_pitch;
      neg = (l == 0) ? rt.neg_roll : rt.neg_pitch;
      r = (cr_lane[CORDIC_STEPS][l].z + AngleWidth'(1 <<< (AngleFrac - 1))) >>> AngleFrac;
      if (r > AngleWidth'(AngleLimit)) begin
        r = AngleWidth'(AngleLimit);
      end else if (r < -AngleWidth'(AngleLimit)) begin
        r = -AngleWidth'(AngleLimit);
      end
      if (rt.zero) begin
        r = '0;
      end else if (dz) begin
        r = neg ? -AngleWidth'(AngleLimit) : AngleWidth'(AngleLimit);
      end
      if (l == 1) begin
        r = -r;
      end
      ang[l] = r[OutWidth-1:0];
    end
  end

  assign res_data = {2'b00, ang[1], ang[0]};

  logic [31:0] skid_data;
  logic        skid_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      skid_full <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_full) begin
        m_tvalid  <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        m_tvalid <= res_valid;
      end
    end else if (en && res_valid) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      if (skid_full) begin
        m_tdata <= skid_data;
        m_tuser <= skid_zero;
      end else begin
        m_tdata <= res_data;
        m_tuser <= rt.zero;
      end
    end else if (en && res_valid) begin
      skid_data <= res_data;
      skid_zero <= rt.zero;
    end
  end

endmodule

// File: hdl/atp_sqrt_cell.sv
// One root bit of the pipelined integer square root, for both angle lanes.
module atp_sqrt_cell
  import atp_pkg::*;
#(
  parameter int BIT = 31
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  tag_t           in_tag,
  input  sq_lane_t [1:0] in_lane,
  output logic           out_valid,
  output tag_t           out_tag,
  output sq_lane_t [1:0] out_lane
);

  sq_lane_t [1:0] lane_next;

  always_comb begin
    logic [RemWidth:0] trial;
    lane_next = in_lane;
    for (int l = 0; l < 2; l++) begin
      trial = ({{(RemWidth + 1 - RootWidth){1'b0}}, in_lane[l].root} << (BIT + 1))
              + ((RemWidth + 1)'(1) << (2 * BIT));
      if ({1'b0, in_lane[l].rem} >= trial) begin
        lane_next[l].rem  = in_lane[l].rem - trial[RemWidth-1:0];
        lane_next[l].root = in_lane[l].root | (RootWidth'(1) << BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag  <= in_tag;
      out_lane <= lane_next;
    end
  end

endmodule

// File: hdl/atp_cordic_cell.sv
// One vectoring CORDIC rotation for both angle lanes.
module atp_cordic_cell
  import atp_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  tag_t           in_tag,
  input  cr_lane_t [1:0] in_lane,
  output logic           out_valid,
  output tag_t           out_tag,
  output cr_lane_t [1:0] out_lane
);

  cr_lane_t [1:0] lane_next;

  always_comb begin
    logic signed [CordicWidth-1:0] dx;
    logic signed [CordicWidth-1:0] dy;
    for (int l = 0; l < 2; l++) begin
      dx = in_lane[l].y >>> STEP;
      dy = in_lane[l].x >>> STEP;
      if (!in_lane[l].y[CordicWidth-1]) begin
        lane_next[l].x = in_lane[l].x + dx;
        lane_next[l].y = in_lane[l].y - dy;
        lane_next[l].z = in_lane[l].z + ATAN_TBL[STEP];
      end else begin
        lane_next[l].x = in_lane[l].x - dx;
        lane_next[l].y = in_lane[l].y + dy;
        lane_next[l].z = in_lane[l].z - ATAN_TBL[STEP];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag  <= in_tag;
      out_lane <= lane_next;
    end
  end

endmodule

// File: hdl/atp_checker.sv
// Port-level assertions for the tilt angle block, bound to the top level.
module atp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);

  a_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped while stalled");

  a_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[29:0] == 30'd0)
    else $error("zero sample with nonzero angles");

  a_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[14:0]) >= -15'sd11520)
              && ($signed(m_tdata[14:0]) <= 15'sd11520)
              && ($signed(m_tdata[29:15]) >= -15'sd11520)
              && ($signed(m_tdata[29:15]) <= 15'sd11520))
    else $error("angle beyond ninety degrees");

  a_backpressure : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no output beat pending");

endmodule

bind accel_tilt_angles atp_checker u_atp_checker (.*);

// File: dv/accel_tilt_angles_chk.sv
`timescale 1ns / 100ps
// Checker: predicts roll and pitch for each accepted sample and compares results.
module accel_tilt_angles_chk
  import atp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [0:0]  m_tuser,
  output int          errors,
  output int          pending,
  output int          results
);

  localparam int Steps = 16;
  localparam int FracBits = 16;

  typedef struct packed {
    logic signed [14:0] roll;
    logic signed [14:0] pitch;
    logic               zero;
  } tilt_t;

  tilt_t tilt_q[$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint atan_deg(longint num, longint unsigned den_sq);
    longint x, y, z, r, dx, dy;
    if (den_sq == 0) return num > 0 ? AngleLimit : (num < 0 ? -AngleLimit : 0);
    x = longint'(isqrt(den_sq << (2 * FracBits)) << GuardBits);
    y = num * (longint'(1) << (FracBits + GuardBits));
    z = 0;
    for (int i = 0; i < Steps && i < TableLen; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TBL[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TBL[i]);
      end
    end
    r = floor_shift(z + (longint'(1) << (AngleFrac - 1)), AngleFrac);
    if (r > AngleLimit) r = AngleLimit;
    if (r < -AngleLimit) r = -AngleLimit;
    return r;
  endfunction

  function automatic tilt_t predict_tilt(logic [47:0] d);
    longint ax, ay, az;
    tilt_t t;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    t = '0;
    if (ax == 0 && ay == 0 && az == 0) begin
      t.zero = 1'b1;
    end else begin
      t.roll = 15'(atan_deg(ay, longint'(ax * ax + az * az)));
      t.pitch = 15'(-atan_deg(ax, longint'(ay * ay + az * az)));
    end
    return t;
  endfunction

  always @(posedge clk) begin
    tilt_t e, a;
    if (rst) begin
      errors <= 0;
      results <= 0;
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready) tilt_q.push_back(predict_tilt(s_tdata));
      if (m_tvalid && m_tready) begin
        a.roll = m_tdata[14:0];
        a.pitch = m_tdata[29:15];
        a.zero = m_tuser[0];
        results <= results + 1;
        if (tilt_q.size() == 0) begin
          if (errors < 10) $display("unexpected result beat roll=%0d pitch=%0d", a.roll, a.pitch);
          errors <= errors + 1;
        end else begin
          e = tilt_q.pop_front();
          if (e != a) begin
            if (errors < 10)
              $display("exp roll=%0d pitch=%0d zero=%0d, got roll=%0d pitch=%0d zero=%0d",
                       e.roll, e.pitch, e.zero, a.roll, a.pitch, a.zero);
            errors <= errors + 1;
          end
        end
      end
      pending <= tilt_q.size();
    end
  end
endmodule

// File: dv/accel_tilt_angles_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives samples through the tilt angle block and gives the verdict.
module accel_tilt_angles_tb;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  int          errors, pending, results;
  int          send_idle = 0, recv_stall = 0;
  longint      cycles = 0;

  accel_tilt_angles dut (.*);
  accel_tilt_angles_chk chk (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    m_tready <= ($urandom_range(99) >= recv_stall);
    if (cycles > 2000000) begin
      $display("accel_tilt_angles: mismatch");
      $finish;
    end
  end

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    logic [15:0] ext [6];
    ext = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h1234};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_sample('0, '0, '0);
    send_sample(16'h0005, '0, '0);
    send_sample(16'hfffb, '0, '0);
    send_sample('0, 16'h7fff, '0);
    send_sample('0, 16'h8000, '0);
    send_sample('0, '0, 16'h8000);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h7fff, 16'h8000, 16'h0001);
    for (int i = 0; i < 12; i++)
      send_sample(ext[$urandom_range(5)], ext[$urandom_range(5)], ext[$urandom_range(5)]);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 49 : 25) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 49 : 25) : 0;
      for (int i = 0; i < 450; i++) send_sample(pick_axis(), pick_axis(), pick_axis());
    end
    s_tvalid <= 1'b0;
    recv_stall = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent 1821 samples: axis extremes, zero denominators, all-zero and random data,");
    $display("under sender gaps and receiver stalls; %0d results checked.", results);
    if (errors == 0) $display("accel_tilt_angles: match");
    else $display("accel_tilt_angles: mismatch");
    $finish;
  end
endmodule
